[design/sprite_attribute_memory_assert.svh]
// Assertion macros for the checker file of the sprite attribute memory.
`ifndef SPRITE_ATTRIBUTE_MEMORY_ASSERT_SVH
`define SPRITE_ATTRIBUTE_MEMORY_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define SAM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked around reset.
`define SAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/sam_pkg.sv]
// Types, constants and size lookup shared by the sprite attribute memory files.
package sam_pkg;

  localparam int ADDR_W    = 10;
  localparam int DATA_W    = 8;
  localparam int DIM_W     = 7;
  localparam int OBJ_COUNT = 128;
  localparam int OBJ_W     = 7;
  localparam int LANES     = 4;
  localparam int HI_BYTES  = 32;
  localparam int HI_W      = 5;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic {
    REG_BASE_SIZE = 1'b0,
    REG_INTERLACE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [2:0] base_size;
    logic       interlace_mode;
  } cfg_t;

  // Data returned by the store in the cycle after a request is taken.
  typedef struct packed {
    logic [DATA_W-1:0] lo_byte;
    logic [DATA_W-1:0] hi_byte;
    logic              big;
  } store_rd_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  localparam logic [DIM_W-1:0] SMALL_W [8] = '{7'd8, 7'd8, 7'd8, 7'd16, 7'd16, 7'd32, 7'd16, 7'd16};
  localparam logic [DIM_W-1:0] LARGE_W [8] = '{7'd16, 7'd32, 7'd64, 7'd32, 7'd64, 7'd64, 7'd32, 7'd32};
  localparam logic [DIM_W-1:0] SMALL_H [8] = '{7'd8, 7'd8, 7'd8, 7'd16, 7'd16, 7'd32, 7'd32, 7'd32};
  localparam logic [DIM_W-1:0] LARGE_H [8] = '{7'd16, 7'd32, 7'd64, 7'd32, 7'd64, 7'd64, 7'd64, 7'd32};

  // Object size from the base size setting and the object's size bit.
  function automatic dims_t obj_dims(input cfg_t cfg, input logic big);
    dims_t d;
    d.width  = big ? LARGE_W[cfg.base_size] : SMALL_W[cfg.base_size];
    d.height = big ? LARGE_H[cfg.base_size] : SMALL_H[cfg.base_size];
    // Interlaced small objects of the two tallest settings are 16 lines high.
    if (!big && cfg.interlace_mode && cfg.base_size[2] && cfg.base_size[1]) begin
      d.height = 7'd16;
    end
    return d;
  endfunction

endpackage

[design/sam_req_if.sv]
// Request channel of the sprite attribute memory.
interface sam_req_if import sam_pkg::*; ();
  logic              valid;
  logic              ready;
  op_t               operation;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output operation, output address, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input address, input write_data,
                  output ready);
endinterface

[design/sam_rsp_if.sv]
// Result channel of the sprite attribute memory.
interface sam_rsp_if import sam_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [DIM_W-1:0]  object_width;
  logic [DIM_W-1:0]  object_height;

  modport source (output valid, output read_data, output object_width, output object_height,
                  input ready);
  modport sink   (input valid, input read_data, input object_width, input object_height,
                  output ready);
endinterface

[design/sprite_attribute_memory.sv]
// Top level of the sprite attribute memory: request stage, store, result register.
//
//   Channel  Direction  Handshake               Carries
//   in_chan  sink       valid / ready           operation, address, write_data
//   out_chan source     valid / ready           read_data, object_width, object_height
//   cfg      APB slave  psel, penable, pready   base_size (0x0), interlace_mode (0x4)
//
// One request can be taken every cycle while no clearing pass runs and no stalled result
// fills both stages. The store registers the addressed byte and size bit when it takes the
// request; the result register loads from them when the request stage moves on.
// After reset a clearing pass over all 128 objects zeroes the low table while in_chan.ready
// stays low; configuration writes are taken throughout.
// A stalled result holds the result register, the request stage behind it then holds
// as well, and outside the clearing pass ready drops only when both are full.
module sprite_attribute_memory import sam_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  sam_req_if.sink           in_chan,
  sam_rsp_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  store_rd_t rd;
  logic      clearing;
  logic      accept;
  logic      s1_adv;
  dims_t     dims;

  // Request stage: what the store's registered outputs belong to.
  logic s1_valid_r;
  logic s1_wr_r;
  logic s1_hi_r;

  // Result register.
  logic              out_valid_r;
  logic [DATA_W-1:0] read_data_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic [DATA_W-1:0] read_data_nxt;

  sam_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The request stage moves on whenever the result register is empty or being drained.
  assign s1_adv        = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !clearing && (!s1_valid_r || s1_adv);
  assign accept        = in_chan.valid && in_chan.ready;

  // The store takes the write and reads the addressed byte and size bit in the same
  // edge, so a size reported for a write already reflects the new size bit.
  sam_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .operation  (in_chan.operation),
    .address    (in_chan.address),
    .write_data (in_chan.write_data),
    .rd         (rd),
    .clearing   (clearing)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wr_r <= (in_chan.operation == OP_WRITE);
      s1_hi_r <= in_chan.address[ADDR_W-1];
    end
  end

  // Writes return zero; high table reads return the packed byte of four objects.
  always_comb begin
    if (s1_wr_r) begin
      read_data_nxt = '0;
    end else if (s1_hi_r) begin
      read_data_nxt = rd.hi_byte;
    end else begin
      read_data_nxt = rd.lo_byte;
    end
  end

  assign dims = obj_dims(cfg, rd.big);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      read_data_r <= read_data_nxt;
      width_r     <= dims.width;
      height_r    <= dims.height;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.read_data     = read_data_r;
  assign out_chan.object_width  = width_r;
  assign out_chan.object_height = height_r;

endmodule

[design/sam_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module sam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/sam_store.sv]
// Object attribute store: four byte-lane RAMs for the low table, flops for the high table.
module sam_store import sam_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  op_t               operation,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] write_data,
  output store_rd_t         rd,
  output logic              clearing
);

  logic [OBJ_W-1:0]  clr_cnt_r;
  logic              clearing_r;
  logic [1:0]        lane_r;
  logic [DATA_W-1:0] hi_r [HI_BYTES];
  logic [DATA_W-1:0] hi_byte_r;
  logic              big_r;

  logic              is_hi;
  logic              is_wr;
  logic [OBJ_W-1:0]  obj;
  logic [HI_W-1:0]   hidx;
  logic [DATA_W-1:0] hbyte;
  logic              big_nxt;
  logic [DATA_W-1:0] lane_rdata [LANES];

  assign is_hi = address[ADDR_W-1];
  assign is_wr = (operation == OP_WRITE);
  assign obj   = address[OBJ_W+1:2];

  // Low table accesses look up the object's own size bit; high table accesses use
  // the byte they name, whose first object is the one reported.
  assign hidx  = is_hi ? address[HI_W-1:0] : address[OBJ_W+1:4];
  assign hbyte = hi_r[hidx];

  always_comb begin
    if (is_hi) begin
      big_nxt = is_wr ? write_data[1] : hbyte[1];
    end else begin
      big_nxt = hbyte[{address[3:2], 1'b1}];
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic lane_we;
    assign lane_we = clearing_r ||
                     (load && is_wr && !is_hi && (address[1:0] == 2'(g)));
    sam_ram #(
      .WIDTH (DATA_W),
      .DEPTH (OBJ_COUNT)
    ) u_ram (
      .clk   (clk),
      .we    (lane_we),
      .waddr (clearing_r ? clr_cnt_r : obj),
      .wdata (clearing_r ? '0 : write_data),
      .re    (load),
      .raddr (obj),
      .rdata (lane_rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      for (int i = 0; i < HI_BYTES; i++) begin
        hi_r[i] <= '0;
      end
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == OBJ_W'(OBJ_COUNT - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (load && is_wr && is_hi) begin
        hi_r[address[HI_W-1:0]] <= write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lane_r    <= address[1:0];
      hi_byte_r <= hbyte;
      big_r     <= big_nxt;
    end
  end

  assign rd.lo_byte = lane_rdata[lane_r];
  assign rd.hi_byte = hi_byte_r;
  assign rd.big     = big_r;
  assign clearing   = clearing_r;

endmodule

[design/sam_cfg.sv]
// APB register block holding the base size and interlace settings.
module sam_cfg import sam_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] base_size_r;
  logic       interlace_r;
  reg_idx_t   idx;

  assign idx    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r <= '0;
      interlace_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_BASE_SIZE: base_size_r <= pwdata[2:0];
        REG_INTERLACE: interlace_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE_SIZE: prdata = APB_DW'(base_size_r);
      REG_INTERLACE: prdata = APB_DW'(interlace_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg.base_size      = base_size_r;
  assign cfg.interlace_mode = interlace_r;

endmodule

[design/sam_checker.sv]
// Port-level checker for the sprite attribute memory and its bind to the top level.
`include "sprite_attribute_memory_assert.svh"

module sam_checker import sam_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] read_data,
  input logic [DIM_W-1:0]  object_width,
  input logic [DIM_W-1:0]  object_height
);

  // A held result keeps its value until it is taken.
  `SAM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(object_width) && $stable(object_height), "result changed while stalled")

  // With an empty result register, a new result comes from a request through the request stage and the result register.
  `SAM_ASSERT(a_out_latency, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a request two cycles earlier")

  // Every reported size is one of the object dimensions.
  `SAM_ASSERT(a_dims_legal, clk, rst_n, out_valid |-> (object_width == 7'd8 || object_width == 7'd16 || object_width == 7'd32 || object_width == 7'd64) && (object_height == 7'd8 || object_height == 7'd16 || object_height == 7'd32 || object_height == 7'd64), "illegal object size")

  // No request can be taken as reset is released, since the low table is then being cleared.
  `SAM_ASSERT_ALWAYS(a_clear_blocks, clk, $rose(rst_n) |-> !in_ready, "request taken during clearing pass")

endmodule

bind sprite_attribute_memory sam_checker u_sam_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .read_data     (out_chan.read_data),
  .object_width  (out_chan.object_width),
  .object_height (out_chan.object_height)
);

[verif/tb_sprite_attribute_memory.sv]
// Self-checking testbench for the sprite attribute memory: random traffic against a predictor.
`timescale 1ns / 100ps

module tb_sprite_attribute_memory;
  import sam_pkg::*;

  // Byte lanes of one object in the low table.
  localparam logic [1:0] LANE_X_LOW = 2'd0;
  localparam logic [1:0] LANE_Y     = 2'd1;
  localparam logic [1:0] LANE_TILE  = 2'd2;
  localparam logic [1:0] LANE_ATTR  = 2'd3;

  // Object dimensions in pixels, indexed by the base size setting.
  localparam logic [6:0] DIM_SMALL_W [8] = '{7'd8, 7'd8, 7'd8, 7'd16, 7'd16, 7'd32, 7'd16, 7'd16};
  localparam logic [6:0] DIM_LARGE_W [8] = '{7'd16, 7'd32, 7'd64, 7'd32, 7'd64, 7'd64, 7'd32, 7'd32};
  localparam logic [6:0] DIM_SMALL_H [8] = '{7'd8, 7'd8, 7'd8, 7'd16, 7'd16, 7'd32, 7'd32, 7'd32};
  localparam logic [6:0] DIM_LARGE_H [8] = '{7'd16, 7'd32, 7'd64, 7'd32, 7'd64, 7'd64, 7'd64, 7'd32};

  // Generous bound on the whole run, in clock cycles.
  localparam int CYCLE_LIMIT = 600000;

  // One object as the predictor keeps it.
  typedef struct packed {
    logic [8:0] x;
    logic [7:0] y;
    logic [7:0] tile;
    logic       nsel;
    logic [2:0] pal;
    logic [1:0] prio;
    logic       hflip;
    logic       vflip;
    logic       big;
  } sprite_t;

  // What one request is expected to return.
  typedef struct packed {
    logic [7:0] read_data;
    logic [6:0] width;
    logic [6:0] height;
  } access_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sam_req_if in_chan ();
  sam_rsp_if out_chan ();

  sprite_attribute_memory u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state: a mirror of the object table and of the two registers.
  sprite_t        sprite_mirror [OBJ_COUNT];
  cfg_t           shadow_cfg;
  access_result_t pending_results [$];

  int error_count = 0;
  int cycle_count = 0;
  int requests_sent = 0;

  // Traffic shaping shared between the request driver and the result sink.
  bit sender_quiet = 1'b0;
  bit sink_quiet = 1'b0;
  int hold_request = 0;
  bit sink_holding = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sprite_attribute_memory");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Idle stretch length: usually from the shortest of three ranges, rarely from the longest.
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 9);
    return $urandom_range(12, 30);
  endfunction

  // Applies one accepted request to the mirror and queues the result it must produce.
  // The sizes are looked up after the write, from the addressed object; for the
  // high table that is the first of the four objects that share the byte.
  function automatic void predict_access(input op_t op, input logic [9:0] addr,
                                         input logic [7:0] wdata);
    int             idx;
    int             k;
    sprite_t        s;
    logic [2:0]     sel;
    access_result_t res;
    res = '0;
    if (!addr[9]) begin
      idx = int'(addr[8:2]);
      s = sprite_mirror[idx];
      case (addr[1:0])
        LANE_X_LOW: begin
          if (op == OP_WRITE) s.x[7:0] = wdata;
          else res.read_data = s.x[7:0];
        end
        LANE_Y: begin
          if (op == OP_WRITE) s.y = wdata;
          else res.read_data = s.y;
        end
        LANE_TILE: begin
          if (op == OP_WRITE) s.tile = wdata;
          else res.read_data = s.tile;
        end
        default: begin
          if (op == OP_WRITE) {s.vflip, s.hflip, s.prio, s.pal, s.nsel} = wdata;
          else res.read_data = {s.vflip, s.hflip, s.prio, s.pal, s.nsel};
        end
      endcase
      sprite_mirror[idx] = s;
    end else begin
      // Address bits 8..5 do not matter here, so the high table repeats every 32 bytes.
      idx = int'(addr[4:0]) * 4;
      for (k = 0; k < 4; k++) begin
        s = sprite_mirror[idx + k];
        if (op == OP_WRITE) begin
          s.x[8] = wdata[2*k];
          s.big  = wdata[2*k+1];
        end else begin
          res.read_data[2*k]   = s.x[8];
          res.read_data[2*k+1] = s.big;
        end
        sprite_mirror[idx + k] = s;
      end
    end
    s = sprite_mirror[idx];
    sel = shadow_cfg.base_size;
    res.width = s.big ? DIM_LARGE_W[sel] : DIM_SMALL_W[sel];
    if (s.big) begin
      res.height = DIM_LARGE_H[sel];
    end else if (shadow_cfg.interlace_mode && sel >= 3'd6) begin
      // Interlaced small objects of the two tallest settings are 16 lines high.
      res.height = 7'd16;
    end else begin
      res.height = DIM_SMALL_H[sel];
    end
    pending_results.push_back(res);
  endfunction

  // Sends one request. It is entered at the step where the previous request was
  // taken, so valid stays high across back-to-back requests; it returns at the step
  // where this one is taken.
  task automatic send_request(input op_t op, input logic [9:0] addr, input logic [7:0] wdata);
    int gap;
    gap = (sender_quiet || $urandom_range(0, 2) != 0) ? 0 : idle_length();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.operation  <= op;
    in_chan.address    <= addr;
    in_chan.write_data <= wdata;
    do @(posedge clk); while (!in_chan.ready);
    predict_access(op, addr, wdata);
    requests_sent++;
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One APB write followed by a read of the same register to check it took.
  task automatic write_register(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) report_mismatch("register readback", int'(prdata), int'(value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only while the block is idle, so drain first.
  task automatic apply_config(input logic [2:0] size_sel, input logic interlace);
    drain_results();
    write_register(REG_BASE_SIZE, APB_DW'(size_sel));
    write_register(REG_INTERLACE, APB_DW'(interlace));
    shadow_cfg.base_size      = size_sel;
    shadow_cfg.interlace_mode = interlace;
  endtask

  // Random traffic. Much of it is object sequences: fill some lanes of one object,
  // set its high-table bits through a random alias, then read everything back.
  // The rest is single reads and writes anywhere in the address space.
  task automatic run_traffic(input int count);
    int         target;
    int         pick;
    int         lane;
    logic [6:0] obj;
    target = requests_sent + count;
    while (requests_sent < target) begin
      pick = $urandom_range(0, 99);
      obj = 7'($urandom_range(0, OBJ_COUNT - 1));
      if (pick < 40) begin
        for (lane = 0; lane < 4; lane++) begin
          if ($urandom_range(0, 3) != 0) begin
            send_request(OP_WRITE, {1'b0, obj, 2'(lane)}, 8'($urandom_range(0, 255)));
          end
        end
        if ($urandom_range(0, 3) != 0) begin
          send_request(OP_WRITE, {1'b1, 4'($urandom_range(0, 15)), obj[6:2]},
                       8'($urandom_range(0, 255)));
        end
        for (lane = 0; lane < 4; lane++) begin
          send_request(OP_READ, {1'b0, obj, 2'(lane)}, 8'($urandom_range(0, 255)));
        end
        send_request(OP_READ, {1'b1, 4'($urandom_range(0, 15)), obj[6:2]},
                     8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
        send_request(OP_READ, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
      end else begin
        send_request(OP_WRITE, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Reset values, full bytes, high-table aliasing and the last object,
  // all at the reset configuration.
  task automatic test_directed_access();
    send_request(OP_READ,  10'd0,    8'h00);
    send_request(OP_READ,  10'd1023, 8'hFF);
    send_request(OP_WRITE, 10'd0,    8'hFF);
    send_request(OP_WRITE, 10'd1,    8'hFF);
    send_request(OP_WRITE, 10'd2,    8'hFF);
    send_request(OP_WRITE, 10'd3,    8'hFF);
    send_request(OP_WRITE, 10'd512,  8'hFF);
    send_request(OP_READ,  10'd0,    8'h00);
    send_request(OP_READ,  10'd1,    8'h00);
    send_request(OP_READ,  10'd2,    8'h00);
    send_request(OP_READ,  10'd3,    8'h00);
    send_request(OP_READ,  10'd512,  8'h00);
    send_request(OP_READ,  10'd544,  8'h00);
    send_request(OP_READ,  10'd992,  8'h00);
    send_request(OP_WRITE, 10'd1023, 8'hAA);
    send_request(OP_READ,  10'd1023, 8'h00);
    send_request(OP_READ,  10'd508,  8'h00);
    send_request(OP_WRITE, 10'd511,  8'h55);
    send_request(OP_READ,  10'd511,  8'h00);
    send_request(OP_WRITE, 10'd800,  8'h55);
    send_request(OP_READ,  10'd512,  8'h00);
    send_request(OP_READ,  10'd0,    8'h00);
    send_request(OP_WRITE, 10'd0,    8'h00);
    send_request(OP_READ,  10'd3,    8'h00);
  endtask

  // Every base size with interlace off and on, extremes included.
  task automatic test_size_settings();
    int sel;
    int il;
    for (sel = 0; sel < 8; sel++) begin
      for (il = 0; il < 2; il++) begin
        apply_config(3'(sel), 1'(il));
        run_traffic(40);
      end
    end
  endtask

  // Random phases under random settings; every fourth phase runs with no idling.
  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 10; phase++) begin
      apply_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      sender_quiet = (phase % 4 == 3);
      sink_quiet   = (phase % 4 == 3);
      run_traffic(90);
    end
    sender_quiet = 1'b0;
    sink_quiet   = 1'b0;
  endtask

  // The sink holds off for a long stretch while requests keep coming, so the
  // pipeline fills up and in_chan.ready has to drop.
  task automatic test_result_backpressure();
    drain_results();
    sender_quiet = 1'b1;
    hold_request = 48;
    while (!sink_holding) @(posedge clk);
    run_traffic(80);
    sender_quiet = 1'b0;
  endtask

  // Short bursts with the sender pausing until everything has come back.
  task automatic test_sender_pause();
    int burst;
    for (burst = 0; burst < 3; burst++) begin
      run_traffic(20);
      drain_results();
    end
  endtask

  initial begin : stimulus
    int i;
    for (i = 0; i < OBJ_COUNT; i++) sprite_mirror[i] = '0;
    shadow_cfg = '0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.operation  <= OP_READ;
    in_chan.address    <= '0;
    in_chan.write_data <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // The block clears its table for a while after reset; requests simply wait
    // for ready, so nothing special is needed here.
    test_directed_access();
    test_size_settings();
    test_random_traffic();
    test_result_backpressure();
    test_sender_pause();

    drain_results();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS sprite_attribute_memory");
    end else begin
      $display("FAIL sprite_attribute_memory");
    end
    $finish;
  end

  // Result sink: random runs of ready and stalls, a forced long hold on request,
  // and no stalls at all while sink_quiet is set. Exactly one assignment per run.
  initial begin : result_sink
    int   run;
    logic level;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        run = hold_request;
        hold_request = 0;
        level = 1'b0;
        sink_holding = 1'b1;
      end else if (sink_quiet) begin
        run = 1;
        level = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        run = idle_length();
        level = 1'b0;
      end else begin
        run = $urandom_range(1, 8);
        level = 1'b1;
      end
      out_chan.ready <= level;
      repeat (run) @(posedge clk);
      sink_holding = 1'b0;
    end
  end

  // Every taken result is checked against the oldest expectation, field by field.
  always @(posedge clk) begin : result_check
    access_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", int'(out_chan.read_data), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_chan.read_data !== want.read_data) begin
          report_mismatch("read_data", int'(out_chan.read_data), int'(want.read_data));
        end
        if (out_chan.object_width !== want.width) begin
          report_mismatch("object_width", int'(out_chan.object_width), int'(want.width));
        end
        if (out_chan.object_height !== want.height) begin
          report_mismatch("object_height", int'(out_chan.object_height), int'(want.height));
        end
      end
    end
  end

endmodule

[filelist.f]
+incdir+design
design/sam_pkg.sv
design/sam_req_if.sv
design/sam_rsp_if.sv
design/sam_ram.sv
design/sam_store.sv
design/sam_cfg.sv
design/sprite_attribute_memory.sv
design/sam_checker.sv
verif/tb_sprite_attribute_memory.sv
